FILE: rtl/tsls_pkg.sv
// shared constants and controller/datapath interface types for the tdm slot level meter
// no dependencies
package tsls_pkg;

    localparam int NUM_SLOTS      = 4;
    localparam int SLOT_W         = 2;
    localparam int SAMPLE_W       = 16;
    localparam int SQ_W           = 2 * SAMPLE_W;
    localparam int SUM_W          = 42;
    localparam int ROOT_W         = 16;
    localparam int RAD_W          = 2 * ROOT_W;
    localparam int DIV_STEPS      = SUM_W;
    localparam int SQRT_STEPS     = ROOT_W;
    localparam int ACC_LAST       = NUM_SLOTS;
    localparam int STEP_W         = 6;
    localparam int MAX_FRAMES_DEF = 2048;

    localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 16'sh8000;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              add;
        logic              div_start;
        logic              div_step;
        logic              sqrt_start;
        logic              sqrt_step;
        logic              out_load;
        logic              clear;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic final_frame;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/tsls_ctrl.sv
// sequencer for the tdm slot level meter: accumulate, divide, square root, emit
// depends on tsls_pkg
module tsls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tsls_pkg::t_sts i_sts,
    output tsls_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_ACC       = 7'b0000010,
        S_DIV_INIT  = 7'b0000100,
        S_DIV       = 7'b0001000,
        S_SQRT_INIT = 7'b0010000,
        S_SQRT      = 7'b0100000,
        S_EMIT      = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    logic [tsls_pkg::STEP_W-1:0]   r_step, n_step;
    logic [tsls_pkg::SLOT_W-1:0]   r_slot, n_slot;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_slot     = r_slot;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.slot = r_slot;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                // multiply slot k while adding the square of slot k-1
                o_cmd.slot = r_step[tsls_pkg::SLOT_W-1:0];
                o_cmd.mul  = (r_step < tsls_pkg::STEP_W'(tsls_pkg::ACC_LAST));
                o_cmd.add  = (r_step != '0);
                if (r_step == tsls_pkg::STEP_W'(tsls_pkg::ACC_LAST)) begin
                    n_slot  = '0;
                    n_state = i_sts.final_frame ? S_DIV_INIT : S_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_step          = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == tsls_pkg::STEP_W'(tsls_pkg::DIV_STEPS - 1)) begin
                    n_state = S_SQRT_INIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SQRT_INIT: begin
                o_cmd.sqrt_start = 1'b1;
                n_step           = '0;
                n_state          = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == tsls_pkg::STEP_W'(tsls_pkg::SQRT_STEPS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_slot == tsls_pkg::SLOT_W'(tsls_pkg::NUM_SLOTS - 1)) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_DIV_INIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_slot  <= n_slot;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_ACC))
        else $error("accepted word did not start accumulation");

    a_div_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < tsls_pkg::STEP_W'(tsls_pkg::DIV_STEPS)))
        else $error("divider step counter out of range");
`endif

endmodule

FILE: rtl/tsls_dp.sv
// datapath of the tdm slot level meter: per-slot statistics, shared squarer,
// restoring divider, digit-by-digit square root and output register; depends on tsls_pkg
module tsls_dp #(
    parameter int MAX_FRAMES = tsls_pkg::MAX_FRAMES_DEF,
    parameter int CNT_W      = 12
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  tsls_pkg::t_cmd                           i_cmd,
    output tsls_pkg::t_sts                           o_sts,
    // slot0, slot1, slot2, slot3 samples
    input  logic [tsls_pkg::NUM_SLOTS*tsls_pkg::SAMPLE_W-1:0] i_s_tdata,
    input  logic                                     i_s_tlast,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // rms_level, peak_level, min_sample, max_sample
    output logic [4*tsls_pkg::SAMPLE_W-1:0]          o_m_tdata,
    // slot_index, count_overflow
    output logic [tsls_pkg::SLOT_W:0]                o_m_tuser,
    output logic                                     o_m_tlast
);

    localparam int NS  = tsls_pkg::NUM_SLOTS;
    localparam int SW  = tsls_pkg::SAMPLE_W;
    localparam int SUW = tsls_pkg::SUM_W;
    localparam int RW  = tsls_pkg::ROOT_W;
    localparam int RDW = tsls_pkg::RAD_W;

    logic signed [SW-1:0]             r_smp [NS];
    logic                             r_final;
    logic                             r_take;
    logic [SUW-1:0]                   r_sum [NS];
    logic [SW-1:0]                    r_peak [NS];
    logic signed [SW-1:0]             r_min [NS];
    logic signed [SW-1:0]             r_max [NS];
    logic [CNT_W-1:0]                 r_count;
    logic                             r_ovf;
    logic [tsls_pkg::SQ_W-1:0]        r_sq;
    logic [tsls_pkg::SLOT_W-1:0]      r_sq_slot;
    logic [CNT_W-1:0]                 r_rem;
    logic [SUW-1:0]                   r_quo;
    logic [RDW-1:0]                   r_rad;
    logic [RW:0]                      r_srem;
    logic [RW-1:0]                    r_root;
    logic                             r_out_valid;
    logic [RW-1:0]                    r_out_rms;
    logic [SW-1:0]                    r_out_peak;
    logic signed [SW-1:0]             r_out_min;
    logic signed [SW-1:0]             r_out_max;
    logic [tsls_pkg::SLOT_W-1:0]      r_out_slot;
    logic                             r_out_ovf;
    logic                             r_out_last;

    logic signed [SW-1:0]             smp_c;
    logic [SW:0]                      neg_c;
    logic [SW-1:0]                    abs_c;
    logic [tsls_pkg::SQ_W-1:0]        sq_c;
    logic [tsls_pkg::SLOT_W-1:0]      sum_addr;
    logic [SUW-1:0]                   sum_rd;
    logic [SUW:0]                     sum_nx;
    logic                             take_c;
    logic [CNT_W:0]                   dtrial;
    logic [CNT_W:0]                   ddiff;
    logic [RW+2:0]                    srem2;
    logic [RW+2:0]                    strial;
    logic [RW+2:0]                    sdiff;

    assign smp_c    = r_smp[i_cmd.slot];
    assign neg_c    = (SW+1)'(0) - {smp_c[SW-1], smp_c};
    assign abs_c    = smp_c[SW-1] ? neg_c[SW-1:0] : smp_c;
    assign sq_c     = tsls_pkg::SQ_W'(abs_c) * tsls_pkg::SQ_W'(abs_c);
    assign sum_addr = i_cmd.div_start ? i_cmd.slot : r_sq_slot;
    assign sum_rd   = r_sum[sum_addr];
    assign sum_nx   = {1'b0, sum_rd} + (SUW+1)'(r_sq);
    assign take_c   = (r_count < CNT_W'(MAX_FRAMES));
    assign dtrial   = {r_rem, r_quo[SUW-1]};
    assign ddiff    = dtrial - {1'b0, r_count};
    assign srem2    = {r_srem, r_rad[RDW-1 -: 2]};
    assign strial   = {1'b0, r_root, 2'b01};
    assign sdiff    = srem2 - strial;

    assign o_sts.final_frame = r_final;
    assign o_sts.out_free    = !r_out_valid || i_m_tready;

    // frame capture and per-slot statistics
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < NS; k++) begin
                r_smp[k] <= i_s_tdata[k*SW +: SW];
            end
            r_final <= i_s_tlast;
            r_take  <= take_c;
        end
        if (i_cmd.mul) begin
            r_sq      <= sq_c;
            r_sq_slot <= i_cmd.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < NS; k++) begin
                r_sum[k]  <= '0;
                r_peak[k] <= '0;
                r_min[k]  <= tsls_pkg::MIN_INIT;
                r_max[k]  <= tsls_pkg::MAX_INIT;
            end
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (take_c) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.mul) begin
                if (abs_c > r_peak[i_cmd.slot]) begin
                    r_peak[i_cmd.slot] <= abs_c;
                end
                if (smp_c < r_min[i_cmd.slot]) begin
                    r_min[i_cmd.slot] <= smp_c;
                end
                if (smp_c > r_max[i_cmd.slot]) begin
                    r_max[i_cmd.slot] <= smp_c;
                end
            end
            if (i_cmd.add && r_take) begin
                // saturate at full scale
                r_sum[sum_addr] <= sum_nx[SUW] ? '1 : sum_nx[SUW-1:0];
            end
        end
    end

    // restoring divider and square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= sum_rd;
        end else if (i_cmd.div_step) begin
            if (dtrial >= {1'b0, r_count}) begin
                r_rem <= ddiff[CNT_W-1:0];
                r_quo <= {r_quo[SUW-2:0], 1'b1};
            end else begin
                r_rem <= dtrial[CNT_W-1:0];
                r_quo <= {r_quo[SUW-2:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_start) begin
            r_rad  <= (r_count == '0) ? '0 : r_quo[RDW-1:0];
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[RDW-3:0], 2'b00};
            if (srem2 >= strial) begin
                r_srem <= sdiff[RW:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_srem <= srem2[RW:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rms  <= r_root;
            r_out_peak <= r_peak[i_cmd.slot];
            r_out_min  <= r_min[i_cmd.slot];
            r_out_max  <= r_max[i_cmd.slot];
            r_out_slot <= i_cmd.slot;
            r_out_ovf  <= r_ovf;
            r_out_last <= (i_cmd.slot == tsls_pkg::SLOT_W'(NS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_max, r_out_min, r_out_peak, r_out_rms};
    assign o_m_tuser  = {r_out_ovf, r_out_slot};
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_load_shows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    a_clear_resets_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0 && !r_ovf))
        else $error("statistics not cleared after last result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAMES))
        else $error("frame count above saturation limit");
`endif

endmodule

FILE: rtl/tdm_slot_level_stats.sv
// per-slot rms, peak, min and max level meter over a four-slot tdm capture
// a frame word is taken in IDLE and accumulated in ACC, and no new word is taken until ACC ends
// on the final frame each slot in turn runs a 42-step divider and a 16-step square root,
// and its result is then loaded into the output register once that register is free
// the next capture may start while the last result is still waiting on the output
// synchronous active-low reset clears all statistics and control at once, no clearing pass
module tdm_slot_level_stats #(
    parameter int MAX_FRAMES = tsls_pkg::MAX_FRAMES_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // slot0_sample, slot1_sample, slot2_sample, slot3_sample
    input  logic [tsls_pkg::NUM_SLOTS*tsls_pkg::SAMPLE_W-1:0] i_s_tdata,
    // final_frame
    input  logic                                     i_s_tlast,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // rms_level, peak_level, min_sample, max_sample
    output logic [4*tsls_pkg::SAMPLE_W-1:0]          o_m_tdata,
    // slot_index, count_overflow
    output logic [tsls_pkg::SLOT_W:0]                o_m_tuser,
    // last_slot
    output logic                                     o_m_tlast
);

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    tsls_pkg::t_cmd cmd;
    tsls_pkg::t_sts sts;

    tsls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsls_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for tdm_slot_level_stats: frames go in on the slave stream, one result
// word per slot comes back on the master stream and is checked against a level-meter predictor
// depends on rtl/tsls_pkg.sv and rtl/tdm_slot_level_stats.sv
module tb_top;

    localparam int MAX_FRAMES = tsls_pkg::MAX_FRAMES_DEF;
    localparam int N_DIR      = 13;
    localparam int DRAIN_CYC  = 80;
    localparam int N_RANDOM   = 165;
    localparam logic [tsls_pkg::SUM_W:0] SUM_SAT = (43'd1 << tsls_pkg::SUM_W) - 43'd1;

    typedef logic [0:tsls_pkg::NUM_SLOTS-1][tsls_pkg::SAMPLE_W-1:0] t_frame;

    typedef struct packed {
        logic [tsls_pkg::SLOT_W-1:0]          slot;
        logic [tsls_pkg::ROOT_W-1:0]          rms;
        logic [tsls_pkg::SAMPLE_W-1:0]        peak;
        logic signed [tsls_pkg::SAMPLE_W-1:0] lo;
        logic signed [tsls_pkg::SAMPLE_W-1:0] hi;
        logic                                 ovf;
        logic                                 last;
    } t_level_rec;

    typedef struct packed {
        t_frame smp;
        logic   fin;
        logic   typed;
        t_frame lvl;
    } t_stim_row;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    // slot0_sample, slot1_sample, slot2_sample, slot3_sample
    logic [tsls_pkg::NUM_SLOTS*tsls_pkg::SAMPLE_W-1:0] i_s_tdata = '0;
    // final_frame
    logic                            i_s_tlast  = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // rms_level, peak_level, min_sample, max_sample
    logic [4*tsls_pkg::SAMPLE_W-1:0] o_m_tdata;
    // slot_index, count_overflow
    logic [tsls_pkg::SLOT_W:0]       o_m_tuser;
    // last_slot
    logic                            o_m_tlast;

    tdm_slot_level_stats #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // predictor state
    logic [tsls_pkg::SUM_W-1:0]           sq_sum [tsls_pkg::NUM_SLOTS];
    logic [tsls_pkg::SAMPLE_W-1:0]        pk     [tsls_pkg::NUM_SLOTS];
    logic signed [tsls_pkg::SAMPLE_W-1:0] lo     [tsls_pkg::NUM_SLOTS];
    logic signed [tsls_pkg::SAMPLE_W-1:0] hi     [tsls_pkg::NUM_SLOTS];
    int unsigned                          frames;
    logic                                 ovf_seen;

    t_level_rec  exp_levels [$];
    int          errors     = 0;
    int          n_frames   = 0;
    int          n_captures = 0;
    int          n_results  = 0;
    int          burst_left = 0;
    int          max_gap    = 4;

    logic [15:0] rx_mask = 16'h0001;
    logic [9:0]  rx_cnt  = '0;

    // directed frames; typed rows are single-frame captures with rms = peak = |sample|
    t_stim_row dir_rows [0:N_DIR-1] = '{
        '{{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 1'b1,
          {16'd0, 16'd0, 16'd0, 16'd0}},
        '{{16'h7fff, 16'h8000, 16'h0001, 16'hffff}, 1'b1, 1'b1,
          {16'd32767, 16'd32768, 16'd1, 16'd1}},
        '{{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, 1'b1,
          {16'd32768, 16'd32768, 16'd32768, 16'd32768}},
        '{{16'h5555, 16'haaaa, 16'h00ff, 16'hff00}, 1'b1, 1'b1,
          {16'd21845, 16'd21846, 16'd255, 16'd256}},
        '{{16'h0064, 16'hff38, 16'h012c, 16'hfe70}, 1'b0, 1'b0, '0},
        '{{16'h7fff, 16'h8000, 16'h0000, 16'h0007}, 1'b0, 1'b0, '0},
        '{{16'hfffb, 16'h0005, 16'h8000, 16'h7fff}, 1'b0, 1'b0, '0},
        '{{16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b1, 1'b0, '0},
        '{{16'h3039, 16'hcfc7, 16'h7fff, 16'h8000}, 1'b0, 1'b0, '0},
        '{{16'h3039, 16'hcfc7, 16'h7fff, 16'h8000}, 1'b0, 1'b0, '0},
        '{{16'h3039, 16'hcfc7, 16'h7fff, 16'h8000}, 1'b1, 1'b0, '0},
        '{{16'h0001, 16'hffff, 16'h0000, 16'h0000}, 1'b0, 1'b0, '0},
        '{{16'h0000, 16'h0000, 16'h0001, 16'hffff}, 1'b1, 1'b0, '0}
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_stats();
        for (int k = 0; k < tsls_pkg::NUM_SLOTS; k++) begin
            sq_sum[k] = '0;
            pk[k]     = '0;
            lo[k]     = tsls_pkg::MIN_INIT;
            hi[k]     = tsls_pkg::MAX_INIT;
        end
        frames   = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic logic [tsls_pkg::ROOT_W-1:0] int_sqrt(
        input logic [tsls_pkg::SUM_W-1:0] n);
        logic [2*tsls_pkg::SUM_W-1:0] root;
        logic [2*tsls_pkg::SUM_W-1:0] trial;
        root = '0;
        for (int b = tsls_pkg::SUM_W / 2; b >= 0; b--) begin
            trial = root | ({{(2*tsls_pkg::SUM_W-1){1'b0}}, 1'b1} << b);
            if (trial * trial <= {{tsls_pkg::SUM_W{1'b0}}, n})
                root = trial;
        end
        return root[tsls_pkg::ROOT_W-1:0];
    endfunction

    function automatic void predict_frame(input t_frame f, input logic fin, input logic keep);
        logic signed [tsls_pkg::SAMPLE_W-1:0] s;
        int                                   mag;
        logic [tsls_pkg::SUM_W:0]             t;
        logic [tsls_pkg::SUM_W-1:0]           mean;
        logic                                 counted;
        t_level_rec                           r;
        counted = frames < MAX_FRAMES;
        if (!counted)
            ovf_seen = 1'b1;
        for (int k = 0; k < tsls_pkg::NUM_SLOTS; k++) begin
            s   = f[k];
            mag = (s < 0) ? -int'(s) : int'(s);
            if (counted) begin
                t = {1'b0, sq_sum[k]} + (tsls_pkg::SUM_W + 1)'(mag)
                                      * (tsls_pkg::SUM_W + 1)'(mag);
                sq_sum[k] = (t > SUM_SAT) ? SUM_SAT[tsls_pkg::SUM_W-1:0]
                                          : t[tsls_pkg::SUM_W-1:0];
            end
            if (mag > int'(pk[k]))
                pk[k] = tsls_pkg::SAMPLE_W'(mag);
            if (s < lo[k])
                lo[k] = s;
            if (s > hi[k])
                hi[k] = s;
        end
        if (counted)
            frames++;
        if (!fin)
            return;
        for (int k = 0; k < tsls_pkg::NUM_SLOTS; k++) begin
            mean   = (frames != 0) ? sq_sum[k] / frames : '0;
            r.slot = tsls_pkg::SLOT_W'(k);
            r.rms  = int_sqrt(mean);
            r.peak = pk[k];
            r.lo   = lo[k];
            r.hi   = hi[k];
            r.ovf  = ovf_seen;
            r.last = (k == tsls_pkg::NUM_SLOTS - 1);
            if (keep)
                exp_levels.push_back(r);
        end
        clear_stats();
    endfunction

    task automatic send_frame(input t_frame f, input logic fin, input logic keep);
        int gap;
        i_s_tdata  <= {f[3], f[2], f[1], f[0]};
        i_s_tlast  <= fin;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_frame(f, fin, keep);
        n_frames++;
        if (fin)
            n_captures++;
        if (burst_left != 0) begin
            burst_left--;
        end else if (max_gap != 0) begin
            gap        = $urandom_range(1, max_gap);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [tsls_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(0, 1) ? 16'($urandom_range(0, 31))
                                           : 16'(-$urandom_range(0, 31));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void check_word(input t_level_rec e);
        t_level_rec got;
        got.slot = o_m_tuser[tsls_pkg::SLOT_W-1:0];
        got.ovf  = o_m_tuser[tsls_pkg::SLOT_W];
        got.rms  = o_m_tdata[15:0];
        got.peak = o_m_tdata[31:16];
        got.lo   = o_m_tdata[47:32];
        got.hi   = o_m_tdata[63:48];
        got.last = o_m_tlast;
        if (got.slot !== e.slot) begin
            $error("slot_index: expected %0d, actual %0d", e.slot, got.slot);
            errors++;
        end
        if (got.rms !== e.rms) begin
            $error("rms_level: expected %0d, actual %0d", e.rms, got.rms);
            errors++;
        end
        if (got.peak !== e.peak) begin
            $error("peak_level: expected %0d, actual %0d", e.peak, got.peak);
            errors++;
        end
        if (got.lo !== e.lo) begin
            $error("min_sample: expected %0d, actual %0d", e.lo, got.lo);
            errors++;
        end
        if (got.hi !== e.hi) begin
            $error("max_sample: expected %0d, actual %0d", e.hi, got.hi);
            errors++;
        end
        if (got.ovf !== e.ovf) begin
            $error("count_overflow: expected %0d, actual %0d", e.ovf, got.ovf);
            errors++;
        end
        if (got.last !== e.last) begin
            $error("last_slot: expected %0d, actual %0d", e.last, got.last);
            errors++;
        end
    endfunction

    // receiver: random ready pattern, reshuffled each time rx_cnt[6:0] returns to zero, with all-ready stretches
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 10'd1;
        if (rx_cnt[6:0] == 7'd0)
            rx_mask <= 16'($urandom) | 16'h0001;
        i_m_tready <= (rx_cnt[9:8] == 2'd3) ? 1'b1 : rx_mask[rx_cnt[3:0]];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (exp_levels.size() == 0) begin
                $error("result word with none expected, slot %0d",
                       o_m_tuser[tsls_pkg::SLOT_W-1:0]);
                errors++;
            end else begin
                check_word(exp_levels.pop_front());
            end
        end
    end

    initial begin
        t_frame     f;
        t_level_rec r;
        int         len;
        clear_stats();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed) begin
                for (int k = 0; k < tsls_pkg::NUM_SLOTS; k++) begin
                    r.slot = tsls_pkg::SLOT_W'(k);
                    r.rms  = dir_rows[i].lvl[k];
                    r.peak = dir_rows[i].lvl[k];
                    r.lo   = dir_rows[i].smp[k];
                    r.hi   = dir_rows[i].smp[k];
                    r.ovf  = 1'b0;
                    r.last = (k == tsls_pkg::NUM_SLOTS - 1);
                    exp_levels.push_back(r);
                end
            end
            send_frame(dir_rows[i].smp, dir_rows[i].fin, !dir_rows[i].typed);
        end

        // hold off until the directed captures have fully drained
        i_s_tvalid <= 1'b0;
        while (exp_levels.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n += len) begin
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            len     = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                for (int k = 0; k < tsls_pkg::NUM_SLOTS; k++)
                    f[k] = pick_sample();
                send_frame(f, i == len - 1, 1'b1);
            end
        end
        i_s_tvalid <= 1'b0;

        while (exp_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d frames in %0d captures sent, %0d slot result words checked",
                 n_frames, n_captures, n_results);
        $display("covered single-frame extremes, short and long captures, stalls on both sides");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
